// File: hw/rtl/block_pool_bump_allocator_defines.svh
// Assertion macros for the block pool bump allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BLOCK_POOL_BUMP_ALLOCATOR_DEFINES_SVH
`define BLOCK_POOL_BUMP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BPA_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("bpba: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BPA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bpba: next-cycle check failed");

`endif

// File: hw/rtl/bpba_pkg.sv
// Shared types and constants of the block pool bump allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpba_pkg;

  localparam int unsigned ALIGN_BYTES     = 32;
  localparam int unsigned NODE_HEADER     = 32;
  localparam int unsigned NEW_BLOCK_START =
      ((NODE_HEADER + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

  localparam logic [16:0] SMALL_LIMIT     = 17'd4095;
  localparam logic [16:0] POOL_MAX        = 17'h10000;
  localparam logic [16:0] POOL_SIZE_RST   = 17'd4096;
  localparam logic [7:0]  FIRST_START_RST = 8'd56;
  localparam logic [2:0]  COUNT_SAT       = 3'd7;
  localparam logic [2:0]  COUNT_MOVE      = 3'd4;

  typedef enum logic [1:0] {
    CMD_ALLOC_ALIGNED   = 2'd0,
    CMD_ALLOC_UNALIGNED = 2'd1,
    CMD_RESET_ALL       = 2'd2,
    CMD_NOP             = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LARGE  = 2'd1,
    ST_CHAIN_FULL = 2'd2
  } status_e;

  typedef enum logic {
    REG_POOL_SIZE   = 1'b0,
    REG_FIRST_START = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CLEAR,
    S_SRCH_RD,
    S_SRCH_EV,
    S_WALK_RD,
    S_WALK_EV,
    S_APPEND,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] request_size;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  block_index;
    logic [16:0] byte_offset;
    logic        block_added;
  } alloc_rsp_t;

  typedef struct packed {
    logic    load_req;
    logic    idx_from_cur;
    logic    idx_from_zero;
    logic    idx_inc;
    logic    fill_rd;
    logic    fill_commit;
    logic    fill_clr;
    logic    cnt_rd;
    logic    cnt_wr;
    logic    append;
    logic    res_set;
    status_e res_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic too_large;
    logic idx_at_end;
    logic walk_at_end;
    logic fit;
    logic chain_full;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpba_ctrl.sv
// Controller state machine of the block pool bump allocator.
// Depends on bpba_pkg; drives bpba_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module bpba_ctrl
  import bpba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output      dp_cmd_t  cmd_o,
  output      logic     busy_o,
  output      logic     done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        unique case (stat_i.command)
          CMD_RESET_ALL: state_d = S_CLEAR;
          CMD_NOP:       state_d = S_DONE;
          CMD_ALLOC_ALIGNED,
          CMD_ALLOC_UNALIGNED: begin
            state_d = stat_i.too_large ? S_DONE : S_SRCH_RD;
          end
        endcase
      end
      S_CLEAR: begin
        if (stat_i.idx_at_end) state_d = S_DONE;
      end
      S_SRCH_RD: begin
        priority if (!stat_i.idx_at_end) state_d = S_SRCH_EV;
        else if (stat_i.chain_full)      state_d = S_DONE;
        else                             state_d = S_WALK_RD;
      end
      S_SRCH_EV: begin
        state_d = stat_i.fit ? S_DONE : S_SRCH_RD;
      end
      S_WALK_RD: begin
        state_d = stat_i.walk_at_end ? S_APPEND : S_WALK_EV;
      end
      S_WALK_EV: state_d = S_WALK_RD;
      S_APPEND:  state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    busy_o           = 1'b1;
    done_o           = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o         = 1'b0;
        cmd_o.load_req = start_i;
      end
      S_CHECK: begin
        unique case (stat_i.command)
          CMD_RESET_ALL: cmd_o.idx_from_zero = 1'b1;
          CMD_NOP:       cmd_o.res_set = 1'b1;
          CMD_ALLOC_ALIGNED,
          CMD_ALLOC_UNALIGNED: begin
            if (stat_i.too_large) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_TOO_LARGE;
            end else begin
              cmd_o.idx_from_cur = 1'b1;
            end
          end
        endcase
      end
      S_CLEAR: begin
        if (stat_i.idx_at_end) begin
          cmd_o.res_set = 1'b1;
        end else begin
          cmd_o.fill_clr = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      S_SRCH_RD: begin
        priority if (!stat_i.idx_at_end) begin
          cmd_o.fill_rd = 1'b1;
        end else if (stat_i.chain_full) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_CHAIN_FULL;
        end else begin
          cmd_o.idx_from_cur = 1'b1;
        end
      end
      S_SRCH_EV: begin
        if (stat_i.fit) cmd_o.fill_commit = 1'b1;
        else            cmd_o.idx_inc     = 1'b1;
      end
      S_WALK_RD: begin
        if (!stat_i.walk_at_end) cmd_o.cnt_rd = 1'b1;
      end
      S_WALK_EV: begin
        cmd_o.cnt_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      S_APPEND: cmd_o.append = 1'b1;
      S_DONE:   done_o = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bpba_datapath.sv
// Datapath of the block pool bump allocator: fill offset and failure
// count memories, chain registers and the fit check. Depends on bpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpba_datapath
  import bpba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  input  wire alloc_req_t  req_i,
  input  wire logic [16:0] pool_size_i,
  input  wire logic [7:0]  first_start_i,
  output      dp_stat_t    stat_o,
  output      alloc_rsp_t  rsp_o
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [17:0] ALIGN_MASK = 18'(ALIGN_BYTES - 1);

  logic [16:0] fill_mem [MAX_BLOCKS];
  logic [2:0]  cnt_mem  [MAX_BLOCKS];

  alloc_req_t  req_q;
  logic [CNT_W-1:0] idx_q, biu_q;
  logic [IDX_W-1:0] cur_q, newcur_q;
  logic        f0_valid_q, c0_valid_q;
  logic [16:0] fill_rdata_q;
  logic [2:0]  cnt_rdata_q;

  logic [1:0]       res_status_q;
  logic [IDX_W-1:0] res_idx_q;
  logic [16:0]      res_off_q;
  logic             res_added_q;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] biu_idx;
  logic        idx_zero;
  logic [16:0] pool_eff, limit;
  logic [17:0] base, blk_end, fill_val, m_val, m_next;
  logic        fit;
  logic [2:0]  cnt_old, cnt_new;
  logic [17:0] new_fill;

  logic        fill_we;
  logic [IDX_W-1:0] fill_wa;
  logic [16:0] fill_wd;
  logic        cnt_we;
  logic [IDX_W-1:0] cnt_wa;
  logic [2:0]  cnt_wd;

  assign idx      = idx_q[IDX_W-1:0];
  assign biu_idx  = biu_q[IDX_W-1:0];
  assign idx_zero = (idx_q == '0);

  // Effective pool size and small request limit
  assign pool_eff = (pool_size_i > POOL_MAX) ? POOL_MAX : pool_size_i;
  assign limit    = (pool_eff < SMALL_LIMIT) ? pool_eff : SMALL_LIMIT;

  // Fit check for the entry at idx
  assign base     = idx_zero ? {10'd0, first_start_i} : 18'(NODE_HEADER);
  assign blk_end  = base + {1'b0, pool_eff};
  assign fill_val = (idx_zero && !f0_valid_q) ? {10'd0, FIRST_START_RST}
                                              : {1'b0, fill_rdata_q};
  assign m_val    = (cmd_e'(req_q.command) == CMD_ALLOC_ALIGNED)
                  ? ((fill_val + ALIGN_MASK) & ~ALIGN_MASK) : fill_val;
  assign fit      = (m_val <= blk_end) &&
                    ((blk_end - m_val) >= {1'b0, req_q.request_size});
  assign m_next   = m_val + {1'b0, req_q.request_size};
  assign new_fill = 18'(NEW_BLOCK_START) + {1'b0, req_q.request_size};

  // Failure count update, saturating
  assign cnt_old = (idx_zero && !c0_valid_q) ? 3'd0 : cnt_rdata_q;
  assign cnt_new = (cnt_old < COUNT_SAT) ? (cnt_old + 3'd1) : cnt_old;

  // Memory write ports
  always_comb begin
    fill_we = 1'b0;
    fill_wa = idx;
    fill_wd = m_next[16:0];
    priority if (cmd_i.fill_commit) begin
      fill_we = 1'b1;
    end else if (cmd_i.fill_clr) begin
      fill_we = 1'b1;
      fill_wd = base[16:0];
    end else if (cmd_i.append) begin
      fill_we = 1'b1;
      fill_wa = biu_idx;
      fill_wd = new_fill[16:0];
    end else begin
      fill_we = 1'b0;
    end
  end

  always_comb begin
    cnt_we = cmd_i.cnt_wr || cmd_i.append;
    cnt_wa = cmd_i.append ? biu_idx : idx;
    cnt_wd = cmd_i.append ? 3'd0 : cnt_new;
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (cmd_i.fill_rd) fill_rdata_q <= fill_mem[idx];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd_i.cnt_rd) cnt_rdata_q <= cnt_mem[idx];
  end

  // Chain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q      <= CNT_W'(1);
      cur_q      <= '0;
      f0_valid_q <= 1'b0;
      c0_valid_q <= 1'b0;
    end else begin
      if (fill_we && (fill_wa == '0)) f0_valid_q <= 1'b1;
      if (cmd_i.cnt_wr && idx_zero)   c0_valid_q <= 1'b1;
      if (cmd_i.append) begin
        biu_q <= biu_q + CNT_W'(1);
        cur_q <= newcur_q;
      end
    end
  end

  // Request, walk index and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    priority if (cmd_i.idx_from_zero) begin
      idx_q <= '0;
    end else if (cmd_i.idx_from_cur) begin
      idx_q    <= CNT_W'(cur_q);
      newcur_q <= cur_q;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CNT_W'(1);
    end else begin
      idx_q <= idx_q;
    end
    if (cmd_i.cnt_wr && (cnt_old > COUNT_MOVE)) newcur_q <= idx + IDX_W'(1);

    priority if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_idx_q    <= '0;
      res_off_q    <= '0;
      res_added_q  <= 1'b0;
    end else if (cmd_i.fill_commit) begin
      res_status_q <= ST_OK;
      res_idx_q    <= idx;
      res_off_q    <= m_val[16:0];
      res_added_q  <= 1'b0;
    end else if (cmd_i.append) begin
      res_status_q <= ST_OK;
      res_idx_q    <= biu_idx;
      res_off_q    <= 17'(NEW_BLOCK_START);
      res_added_q  <= 1'b1;
    end else begin
      res_status_q <= res_status_q;
    end
  end

  always_comb begin
    stat_o.command     = cmd_e'(req_q.command);
    stat_o.too_large   = (req_q.request_size > limit);
    stat_o.idx_at_end  = (idx_q >= biu_q);
    stat_o.walk_at_end = ({1'b0, idx_q} + (CNT_W+1)'(1)) >= {1'b0, biu_q};
    stat_o.fit         = fit;
    stat_o.chain_full  = (biu_q == CNT_W'(MAX_BLOCKS));
  end

  assign rsp_o.status      = res_status_q;
  assign rsp_o.block_index = 4'(res_idx_q);
  assign rsp_o.byte_offset = res_off_q;
  assign rsp_o.block_added = res_added_q;

endmodule

`default_nettype wire

// File: hw/rtl/block_pool_bump_allocator.sv
// Block pool bump allocator: top level with the APB register file.
// Depends on bpba_pkg, bpba_ctrl, bpba_datapath and the defines header.
//
// Issue a command word on req_i with start high while busy is low; it is
// taken at that edge. Commands: aligned alloc, unaligned alloc, rewind all
// blocks, no-op. One result word follows on rsp_o, marked by done_o for a
// single cycle; the receiver cannot stall and must take it then. busy stays
// high from the cycle after acceptance through the done cycle, so the next
// word is taken in the cycle after done at the earliest.
// The first-fit search and the failure-count walk each visit one block at a
// time, in a read state and then an evaluate state, through the registered
// read port of their memory.
// Reset clears the chain to one block with its fill offset at the reset value
// of first_block_start; no clearing pass is needed.
// Registers (APB, byte address 4*i): pool_size, first_block_start; write them
// only while busy is low.
`timescale 1ns / 1ps
`default_nettype none
`include "block_pool_bump_allocator_defines.svh"

module block_pool_bump_allocator
  import bpba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        start,
  output      logic        busy,
  input  wire alloc_req_t  req_i,
  // result channel
  output      logic        done_o,
  output      alloc_rsp_t  rsp_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic [16:0] pool_size_q;
  logic [7:0]  first_start_q;
  logic        cfg_wr;
  reg_idx_e    reg_sel;
  dp_cmd_t     dp_cmd;
  dp_stat_t    dp_stat;

  // Register file: decode on the word address, ignore the byte lanes
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q   <= POOL_SIZE_RST;
      first_start_q <= FIRST_START_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_POOL_SIZE:   pool_size_q   <= pwdata[16:0];
        REG_FIRST_START: first_start_q <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POOL_SIZE:   prdata = {15'd0, pool_size_q};
      REG_FIRST_START: prdata = {24'd0, first_start_q};
    endcase
  end

  // Sequencer: a read state and an evaluate state for each block of the search or walk
  bpba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // Memories, chain registers and the fit check
  bpba_datapath #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .req_i        (req_i),
    .pool_size_i  (pool_size_q),
    .first_start_i(first_start_q),
    .stat_o       (dp_stat),
    .rsp_o        (rsp_o)
  );

  // An accepted word keeps the block busy in the next cycle
  `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // One result word per command: the strobe is never held high across a clock edge
  `BPA_ASSERT_NEXT(a_done_single, done_o, !done_o)
  // The result appears only while the block is still marked busy
  `BPA_ASSERT_IMPL(a_done_busy, done_o, busy)
  // A failed request carries no placement
  `BPA_ASSERT_IMPL(a_fail_clean, done_o && (rsp_o.status != ST_OK),
                   !rsp_o.block_added && (rsp_o.byte_offset == '0))

endmodule

`default_nettype wire
